>>> rtl/ic_pkg.sv
package ic_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned TOTAL_W       = 11;

  typedef struct packed {
    logic vld;
    logic wr;
    logic last;
    logic ovf;
  } ic_ctl_t;

endpackage

>>> rtl/ic_cell.sv
module ic_cell #(
  parameter int unsigned SLOT_W = 6,
  parameter int unsigned CNT_W  = 6,
  parameter int unsigned IDX    = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ic_pkg::ic_ctl_t              in_ctl,
  input  logic [ic_pkg::VALUE_W-1:0]   in_value,
  input  logic [SLOT_W-1:0]            in_slot,
  input  logic [CNT_W-1:0]             in_cnt,
  output ic_pkg::ic_ctl_t              out_ctl,
  output logic [ic_pkg::VALUE_W-1:0]   out_value,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [CNT_W-1:0]             out_cnt
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [ic_pkg::VALUE_W-1:0] stored_r;
  ic_pkg::ic_ctl_t            ctl_r;
  logic [ic_pkg::VALUE_W-1:0] value_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       hit;
  logic                       wr_here;
  logic [CNT_W-1:0]           cnt_nxt;

  // cells below the token's slot hold earlier values of the same sequence
  assign hit     = in_ctl.vld && in_ctl.wr && (MY_SLOT < in_slot) && (stored_r > in_value);
  assign wr_here = in_ctl.vld && in_ctl.wr && (in_slot == MY_SLOT);
  assign cnt_nxt = in_cnt + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (wr_here) begin
      stored_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= in_value;
    slot_r  <= in_slot;
    cnt_r   <= cnt_nxt;
  end

  assign out_ctl   = ctl_r;
  assign out_value = value_r;
  assign out_slot  = slot_r;
  assign out_cnt   = cnt_r;

endmodule

>>> rtl/inversion_counter_core.sv
// Channel   Ports                                       Handshake
// in        in_value, in_last                           start && !busy
// out       out_inversion_count, out_overflow           out_valid strobe, one cycle
//
// One beat is taken every cycle; busy stays low.
// Each beat walks the cell row, one cell per cycle, comparing against the value held
// in every earlier slot; after the last cell its result is registered once more before it leaves.
// Reset (synchronous, rst_n low) drops beats in flight and clears fill and totals.
// The receiver cannot stall: results are strobed for exactly one cycle.
module inversion_counter_core #(
  parameter int unsigned MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ic_pkg::VALUE_W-1:0]    in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic [ic_pkg::TOTAL_W-1:0]    out_inversion_count,
  output logic                          out_overflow
);

  localparam int unsigned SLOT_W = $clog2(MAX_ITEMS);
  localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CNT_W  = SLOT_W;
  localparam int unsigned SUM_W  = ic_pkg::TOTAL_W + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_ITEMS);

  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [ic_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                       out_valid_r;
  logic [ic_pkg::TOTAL_W-1:0] out_count_r;
  logic                       out_ovf_r;
  logic                       accept;
  logic                       room;
  logic [SUM_W-1:0]           sum;
  logic [ic_pkg::TOTAL_W-1:0] sat;

  ic_pkg::ic_ctl_t            ch_ctl   [MAX_ITEMS+1];
  logic [ic_pkg::VALUE_W-1:0] ch_value [MAX_ITEMS+1];
  logic [SLOT_W-1:0]          ch_slot  [MAX_ITEMS+1];
  logic [CNT_W-1:0]           ch_cnt   [MAX_ITEMS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign room   = (fill_r != FILL_MAX);

  // head of the row
  assign ch_ctl[0]   = '{vld: accept, wr: room, last: in_last, ovf: (ovf_r || !room)};
  assign ch_value[0] = in_value;
  assign ch_slot[0]  = fill_r[SLOT_W-1:0];
  assign ch_cnt[0]   = '0;

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (in_last) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        ovf_nxt = ovf_r || !room;
        if (room) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    ic_cell #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .IDX    (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_ctl    (ch_ctl[k]),
      .in_value  (ch_value[k]),
      .in_slot   (ch_slot[k]),
      .in_cnt    (ch_cnt[k]),
      .out_ctl   (ch_ctl[k+1]),
      .out_value (ch_value[k+1]),
      .out_slot  (ch_slot[k+1]),
      .out_cnt   (ch_cnt[k+1])
    );
  end

  // tail: saturating accumulate
  assign sum = SUM_W'(total_r) + SUM_W'(ch_cnt[MAX_ITEMS]);
  assign sat = sum[ic_pkg::TOTAL_W] ? '1 : sum[ic_pkg::TOTAL_W-1:0];

  always_comb begin
    total_nxt = total_r;
    if (ch_ctl[MAX_ITEMS].vld) begin
      total_nxt = ch_ctl[MAX_ITEMS].last ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= ch_ctl[MAX_ITEMS].vld && ch_ctl[MAX_ITEMS].last;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= sat;
    out_ovf_r   <= ch_ctl[MAX_ITEMS].ovf;
  end

  assign out_valid           = out_valid_r;
  assign out_inversion_count = out_count_r;
  assign out_overflow        = out_ovf_r;

endmodule

>>> rtl/ic_checker.sv
module ic_checker #(
  parameter int unsigned MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_last,
  input logic                          out_valid,
  input logic [ic_pkg::TOTAL_W-1:0]    out_inversion_count,
  input logic                          out_overflow
);

  localparam int unsigned LAT = MAX_ITEMS + 1;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_quiet_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |-> ##LAT out_valid)
    else $error("final beat produced no result");

  a_result_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_last, LAT))
    else $error("result without a final beat");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_inversion_count, out_overflow}))
    else $error("result beat carries unknown bits");

endmodule

bind inversion_counter_core ic_checker #(.MAX_ITEMS(MAX_ITEMS)) u_ic_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_last             (in_last),
  .out_valid           (out_valid),
  .out_inversion_count (out_inversion_count),
  .out_overflow        (out_overflow)
);

>>> dv/inversion_counter_checker.sv
module inversion_counter_checker #(
  parameter int unsigned MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [ic_pkg::VALUE_W-1:0] in_value,
  input  logic                       in_last,
  input  logic                       out_valid,
  input  logic [ic_pkg::TOTAL_W-1:0] out_inversion_count,
  input  logic                       out_overflow,
  output int                         fail_count,
  output int                         pending
);

  localparam int unsigned TOTAL_SAT = (1 << ic_pkg::TOTAL_W) - 1;

  typedef struct packed {
    logic [ic_pkg::TOTAL_W-1:0] count;
    logic                       ovf;
  } seq_result_t;

  seq_result_t                expected_totals[$];
  logic [ic_pkg::VALUE_W-1:0] seen_vals[MAX_ITEMS];
  int unsigned                seen_n;
  int unsigned                run_total;
  logic                       seq_ovf;

  always @(posedge clk) begin
    seq_result_t got;
    seq_result_t want;
    int unsigned greater;
    if (!rst_n) begin
      seen_n    = 0;
      run_total = 0;
      seq_ovf   = 1'b0;
      expected_totals.delete();
    end else begin
      if (out_valid) begin
        got.count = out_inversion_count;
        got.ovf   = out_overflow;
        if (expected_totals.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: expected=none actual count=%0d overflow=%0b",
                   $time, got.count, got.ovf);
        end else begin
          want = expected_totals.pop_front();
          if (got.count !== want.count) begin
            fail_count++;
            $display("%0t: inversion_count mismatch: expected=%0d actual=%0d",
                     $time, want.count, got.count);
          end
          if (got.ovf !== want.ovf) begin
            fail_count++;
            $display("%0t: overflow mismatch: expected=%0b actual=%0b",
                     $time, want.ovf, got.ovf);
          end
        end
      end
      if (start && !busy) begin
        if (seen_n < MAX_ITEMS) begin
          greater = 0;
          for (int unsigned k = 0; k < seen_n; k++) begin
            if (seen_vals[k] > in_value) greater++;
          end
          run_total = run_total + greater;
          if (run_total > TOTAL_SAT) run_total = TOTAL_SAT;
          seen_vals[seen_n] = in_value;
          seen_n++;
        end else begin
          seq_ovf = 1'b1;
        end
        if (in_last) begin
          want.count = run_total[ic_pkg::TOTAL_W-1:0];
          want.ovf   = seq_ovf;
          expected_totals = {expected_totals, want};
          seen_n    = 0;
          run_total = 0;
          seq_ovf   = 1'b0;
        end
      end
    end
    pending = expected_totals.size();
  end

endmodule

>>> dv/tb_top.sv
module tb_top;

  localparam int unsigned VAL_W        = ic_pkg::VALUE_W;
  localparam int unsigned SEQ_MAX      = ic_pkg::MAX_ITEMS_DEF;
  localparam int unsigned DRAIN_CYCLES = SEQ_MAX + 20;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_BEATS = 480;
  localparam int unsigned IDLE_PCT[4]  = '{0, 86, 0, 31};

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [VAL_W-1:0]           in_value;
  logic                       in_last;
  logic                       out_valid;
  logic [ic_pkg::TOTAL_W-1:0] out_inversion_count;
  logic                       out_overflow;

  int          fail_count;
  int          pending;
  int unsigned sender_idle_pct;
  int unsigned quiet_cycles;
  int unsigned beats_sent;

  inversion_counter_core #(
    .MAX_ITEMS(SEQ_MAX)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_inversion_count(out_inversion_count),
    .out_overflow       (out_overflow)
  );

  inversion_counter_checker #(
    .MAX_ITEMS(SEQ_MAX)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_inversion_count(out_inversion_count),
    .out_overflow       (out_overflow),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // entered and left at a falling edge; start stays high on return
  task automatic send_beat(input logic [VAL_W-1:0] v, input logic l);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do begin
      @(posedge clk);
    end while (busy);
    beats_sent++;
    @(negedge clk);
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned seq_len;
    int unsigned val_mode;
    int unsigned r;
    logic [VAL_W-1:0] v;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_value        = '0;
    in_last         = 1'b0;
    sender_idle_pct = 0;
    beats_sent      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-item sequences at both extremes
    send_beat(16'hFFFF, 1'b1);
    send_beat(16'h0000, 1'b1);
    // one inversion, extremes
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b1);
    // ties do not count
    send_beat(16'h0007, 1'b0);
    send_beat(16'h0007, 1'b0);
    send_beat(16'h0007, 1'b1);
    // strictly descending
    send_beat(16'h0003, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0000, 1'b1);
    // ascending
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    // mixed around the msb
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0001, 1'b1);

    // full store, fully descending: largest count
    for (int unsigned k = 0; k < SEQ_MAX; k++) begin
      send_beat(16'hFFFF - k[VAL_W-1:0], k == SEQ_MAX - 1);
    end
    // first beat past the store carries last
    for (int unsigned k = 0; k <= SEQ_MAX; k++) begin
      send_beat(VAL_W'($urandom), k == SEQ_MAX);
    end
    // several beats past the store
    for (int unsigned k = 0; k < SEQ_MAX + 6; k++) begin
      send_beat(VAL_W'($urandom), k == SEQ_MAX + 5);
    end

    rand_base = beats_sent;
    while (beats_sent - rand_base < RANDOM_BEATS) begin
      sender_idle_pct = IDLE_PCT[(beats_sent - rand_base) * 4 / RANDOM_BEATS];
      r = $urandom_range(99);
      if (r < 80) seq_len = $urandom_range(12, 1);
      else if (r < 93) seq_len = $urandom_range(SEQ_MAX - 1, 13);
      else seq_len = $urandom_range(SEQ_MAX + 8, SEQ_MAX);
      val_mode = $urandom_range(2);
      for (int unsigned k = 0; k < seq_len; k++) begin
        case (val_mode)
          0: v = VAL_W'($urandom);
          1: v = VAL_W'($urandom_range(7));
          default: begin
            r = $urandom_range(2);
            v = (r == 0) ? '0 : (r == 1) ? '1 : VAL_W'($urandom);
          end
        endcase
        send_beat(v, k == seq_len - 1);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ic_pkg.sv
rtl/ic_cell.sv
rtl/inversion_counter_core.sv
rtl/ic_checker.sv
dv/inversion_counter_checker.sv
dv/tb_top.sv
